### hw/rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, sizes and helpers for the associative cache replacement core.
// ----------------------------------------------------------------------------
package acr_pkg;

  // store geometry
  localparam int LINES        = 16;
  localparam int TAG_BITS     = 16;
  localparam int COUNTER_BITS = 16;
  localparam int IDX_W        = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int LP           = 1 << IDX_W;

  // beat field widths
  localparam int ADDR_W = 16;
  localparam int PICK_W = 4;
  localparam int LINE_W = 4;
  localparam int MOD_W  = ((PICK_W > IDX_W) ? PICK_W : IDX_W) + 1;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    POL_LRU    = 2'd0,
    POL_FIFO   = 2'd1,
    POL_LFU    = 2'd2,
    POL_RANDOM = 2'd3
  } policy_t;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [TAG_BITS-1:0]     tag_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // saturating increment
  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == '1) ? c : c + COUNTER_BITS'(1);
  endfunction

  // random pick reduced modulo the line count by repeated subtraction
  function automatic idx_t pick_mod(input logic [PICK_W-1:0] p);
    logic [MOD_W-1:0] v;
    v = MOD_W'(p);
    for (int k = 0; k < 8; k++) begin
      if (v >= MOD_W'(LINES)) begin
        v = v - MOD_W'(LINES);
      end
    end
    return IDX_W'(v);
  endfunction

endpackage

### hw/rtl/assoc_cache_replacement_core.sv
// ----------------------------------------------------------------------------
// assoc_cache_replacement_core
// Fully associative tag store with LRU, FIFO, LFU and random replacement.
// ----------------------------------------------------------------------------
// Takes one access beat per cycle unless out_ready holds back a full result
// register, and presents one result beat per access after it passes the
// input register and then the result register. All lines are compared in
// parallel and the replacement victim is found by a comparison tree over the
// line counters, so the tag compare plus counter select between the input
// register and the result register sets the cycle time. Line state is
// updated in the same cycle the result is registered, so the next access
// always sees the effect of the previous one. The valid bits and counters
// clear at reset; tags are only read while valid.
module assoc_cache_replacement_core (
  input  logic                          clk,
  input  logic                          rst,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acr_pkg::PADDR_W-1:0]   paddr,
  input  logic [acr_pkg::PDATA_W-1:0]   pwdata,
  output logic [acr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // access channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [acr_pkg::ADDR_W-1:0]    block_address,
  input  logic [acr_pkg::PICK_W-1:0]    random_pick,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [acr_pkg::LINE_W-1:0]    line_index,
  output logic                          evicted_valid,
  output logic [acr_pkg::ADDR_W-1:0]    evicted_tag
);
  import acr_pkg::*;

  policy_t policy_mode;

  // line state
  tag_t               line_tags [LINES];
  logic [LINES-1:0]   line_valid;
  cnt_t               line_counters [LINES];

  // input register
  logic               s1_valid;
  tag_t               s1_tag;
  logic [PICK_W-1:0]  s1_pick;

  logic adv;

  // lookup signals
  logic [LINES-1:0]   match_vec;
  logic               hit_c;
  idx_t               hit_line;
  idx_t               free_line;
  logic               all_valid;
  cnt_t               cmp_cnt [LP];
  cnt_t               node_cnt [1:2*LP-1];
  idx_t               node_idx [1:2*LP-1];
  logic               node_ok  [1:2*LP-1];
  logic               right_better;
  idx_t               victim;
  idx_t               line_sel;
  logic               ev_valid_c;
  tag_t               ev_tag_c;
  cnt_t               counters_next [LINES];

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= POL_LRU;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POLICY)) begin
      policy_mode <= policy_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_POLICY) begin
      prdata = PDATA_W'(policy_mode);
    end
  end

  // handshake: stage 1 moves on when the result register is free or draining
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tag  <= TAG_BITS'(block_address);
      s1_pick <= random_pick;
    end
  end

  // parallel tag compare, lowest index wins
  always_comb begin
    hit_line = '0;
    hit_c    = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      match_vec[i] = line_valid[i] && (line_tags[i] == s1_tag);
    end
    for (int i = LINES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_line = IDX_W'(i);
        hit_c    = 1'b1;
      end
    end
  end

  // first invalid line
  always_comb begin
    free_line = '0;
    all_valid = &line_valid;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (!line_valid[i]) begin
        free_line = IDX_W'(i);
      end
    end
  end

  // counters as seen by the victim search (after fifo ageing)
  always_comb begin
    for (int i = 0; i < LP; i++) begin
      cmp_cnt[i] = '0;
    end
    for (int i = 0; i < LINES; i++) begin
      cmp_cnt[i] = (policy_mode == POL_FIFO) ? sat_inc(line_counters[i])
                                             : line_counters[i];
    end
  end

  // min/max tree, ties kept on the left (lower index)
  always_comb begin
    right_better = 1'b0;
    for (int i = 0; i < LP; i++) begin
      node_cnt[LP+i] = cmp_cnt[i];
      node_idx[LP+i] = IDX_W'(i);
      node_ok[LP+i]  = (i < LINES);
    end
    for (int n = LP - 1; n >= 1; n--) begin
      if (policy_mode == POL_LFU) begin
        right_better = node_cnt[2*n+1] < node_cnt[2*n];
      end else begin
        right_better = node_cnt[2*n+1] > node_cnt[2*n];
      end
      if (node_ok[2*n+1] && (right_better || !node_ok[2*n])) begin
        node_cnt[n] = node_cnt[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_cnt[n] = node_cnt[2*n];
        node_idx[n] = node_idx[2*n];
      end
      node_ok[n] = node_ok[2*n] || node_ok[2*n+1];
    end
  end

  // victim choice and eviction report
  always_comb begin
    if (policy_mode == POL_RANDOM) begin
      victim = pick_mod(s1_pick);
    end else if (!all_valid) begin
      victim = free_line;
    end else begin
      victim = node_idx[1];
    end
    line_sel   = hit_c ? hit_line : victim;
    ev_valid_c = !hit_c && line_valid[victim];
    ev_tag_c   = ev_valid_c ? line_tags[victim] : '0;
  end

  // counter update per line
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      counters_next[i] = line_counters[i];
      if (policy_mode == POL_FIFO && line_valid[i]) begin
        counters_next[i] = sat_inc(line_counters[i]);
      end
      if (IDX_W'(i) == line_sel) begin
        if (!hit_c || policy_mode == POL_LRU) begin
          counters_next[i] = '0;
        end else if (policy_mode == POL_LFU) begin
          counters_next[i] = sat_inc(line_counters[i]);
        end
      end else if (policy_mode == POL_LRU && line_valid[i]) begin
        counters_next[i] = sat_inc(line_counters[i]);
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      for (int i = 0; i < LINES; i++) begin
        line_counters[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < LINES; i++) begin
        line_counters[i] <= counters_next[i];
      end
      if (!hit_c) begin
        line_valid[victim] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !hit_c) begin
      line_tags[victim] <= s1_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit           <= hit_c;
      line_index    <= LINE_W'(line_sel);
      evicted_valid <= ev_valid_c;
      evicted_tag   <= ADDR_W'(ev_tag_c);
    end
  end

  // checks
  a_tag_unique: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(match_vec))
    else $error("tag present in more than one valid line");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid && (evicted_tag == '0))
    else $error("hit beat reports an eviction");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    adv && !hit_c |=> line_valid[$past(victim)])
    else $error("filled line not marked valid");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("access stalled with empty result register");

endmodule
